[hw/rtl/sitoa_pkg.sv]
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types, constants and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int CHAR_WIDTH          = 6;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(48);
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

   // Decimal digits needed to hold any unsigned value of width w:
   // floor(w * log10(2)) + 1, with log10(2) taken as 1233 / 4096.
   function automatic int num_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift_digit;
      logic sel_sign;
   } dp_cmd_type;

   typedef struct packed {
      logic neg;
      logic top_zero;
   } dp_status_type;

endpackage

[hw/rtl/sitoa_if.sv]
// ----------------------------------------------------------------------------
// sitoa_if
// Valid/ready channels of the converter: integer requests and character
// responses.
// ----------------------------------------------------------------------------
interface sitoa_req_if #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_rsp_if;
   import sitoa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

[hw/rtl/sitoa_datapath.sv]
// ----------------------------------------------------------------------------
// sitoa_datapath
// Magnitude register, shift-add-3 binary to BCD converter and digit output
// shifter.
// ----------------------------------------------------------------------------
module sitoa_datapath #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic [VALUE_WIDTH-1:0]             value,
   input  sitoa_pkg::dp_cmd_type              cmd,
   output sitoa_pkg::dp_status_type           status,
   output logic [sitoa_pkg::CHAR_WIDTH-1:0]   character
);
   import sitoa_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
   localparam int BCD_WIDTH  = NUM_DIGITS * 4;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic [VALUE_WIDTH-1:0] mag_load;
   logic [3:0]             top_digit;

   // Magnitude in unsigned arithmetic: the most negative value maps to itself.
   assign mag_load = value[VALUE_WIDTH-1] ? ('0 - value) : value;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? (bcd_ff[d*4 +: 4] + 4'd3)
                                                      : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         mag_in = mag_load;
         bcd_in = '0;
         neg_in = value[VALUE_WIDTH-1];
      end else if (cmd.dabble) begin
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
      end else if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign top_digit       = bcd_ff[BCD_WIDTH-1 -: 4];
   assign status.neg      = neg_ff;
   assign status.top_zero = (top_digit == 4'd0);
   assign character       = cmd.sel_sign ? ASCII_MINUS
                                         : (ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, top_digit});

endmodule

[hw/rtl/sitoa_ctrl.sv]
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: load, convert one bit per cycle, drop leading zeros, then send
// the sign and digits one beat at a time.
// ----------------------------------------------------------------------------
module sitoa_ctrl #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     last_char,
   input  sitoa_pkg::dp_status_type status,
   output sitoa_pkg::dp_cmd_type    cmd
);
   import sitoa_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
   localparam int BCW        = $clog2(VALUE_WIDTH);
   localparam int DCW        = $clog2(NUM_DIGITS);
   localparam logic [BCW-1:0] BIT_LAST   = BCW'(VALUE_WIDTH - 1);
   localparam logic [DCW-1:0] DIGIT_LAST = DCW'(NUM_DIGITS - 1);

   state_type        state_ff, state_in;
   logic [BCW-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]   digit_cnt_ff, digit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         digit_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         digit_cnt_ff <= digit_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      last_char    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_LAST) begin
               digit_cnt_in = DIGIT_LAST;
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, but always keep the units digit
            if (status.top_zero && digit_cnt_ff != '0) begin
               cmd.shift_digit = 1'b1;
               digit_cnt_in    = digit_cnt_ff - 1'b1;
            end else begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            last_char = (digit_cnt_ff == '0);
            if (rsp_ready) begin
               if (last_char) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.shift_digit = 1'b1;
                  digit_cnt_in    = digit_cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response beat is pending");

   a_load_starts_convert: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CONVERT && bit_cnt_ff == '0))
      else $error("accepted request did not start conversion");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(last_char)
                                     && $stable(digit_cnt_ff)))
      else $error("stalled response beat changed");

   a_convert_to_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && bit_cnt_ff == BIT_LAST) |=>
         (state_ff == ST_SKIP && digit_cnt_ff == DIGIT_LAST))
      else $error("conversion did not end after the last bit");

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per
// response beat, most significant first.
// ----------------------------------------------------------------------------
// One request carries a two's complement value of VALUE_WIDTH bits; the
// response channel returns '-' for a negative value, then the decimal digits
// without leading zeros, with last_char set on the final digit (zero gives
// the single digit '0'). One request is handled at a time: the binary to BCD
// conversion handles one input bit per cycle, then the digit shifter walks all
// num_digits(VALUE_WIDTH) digit places, one per cycle unless the receiver holds
// off a beat, dropping leading zeros and sending the rest.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   sitoa_req_if.sink    req_bus,
   sitoa_rsp_if.source  rsp_bus
);
   import sitoa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sitoa_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .last_char (rsp_bus.last_char),
      .status    (status),
      .cmd       (cmd)
   );

   sitoa_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .value     (req_bus.value),
      .cmd       (cmd),
      .status    (status),
      .character (rsp_bus.character)
   );

endmodule

[verif/signed_int_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Integers go in on the request channel and every response beat is checked
// against text spelled out here: a '-' for negative values, then the decimal
// digits without leading zeros, last_char on the final digit. A directed set
// covers zero, single digits, the 10, 100 and 10**9 boundaries and both ends of
// the 32-bit range; a random set follows, weighted by digit count and sign.
// The sender runs in bursts with gaps, the receiver stalls on a rotating
// pattern and, once, for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
   import sitoa_pkg::*;

   localparam int VALUE_WIDTH  = 32;
   localparam int CLOCK_HIGH   = 6;
   localparam int CLOCK_LOW    = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 320;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_START   = 8000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last_char;
   } text_beat_type;

   class decimal_text_scoreboard;
      text_beat_type expected_text[$];
      int            error_count;

      function new();
         error_count = 0;
      endfunction

      task report(input string msg);
         error_count++;
         if (error_count <= 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
         end
      endtask

      // Spell the value in decimal and queue one beat per character.
      function void note_value(input logic [VALUE_WIDTH-1:0] value);
         logic [VALUE_WIDTH-1:0] magnitude;
         longint unsigned        rest;
         int                     digits[$];
         text_beat_type          beat;
         magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
         rest = magnitude;
         do begin
            digits.push_front(int'(rest % 10));
            rest = rest / 10;
         end while (rest != 0);
         if (value[VALUE_WIDTH-1]) begin
            beat.character = ASCII_MINUS;
            beat.last_char = 1'b0;
            expected_text.push_back(beat);
         end
         foreach (digits[i]) begin
            beat.character = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
            beat.last_char = (i == digits.size() - 1);
            expected_text.push_back(beat);
         end
      endfunction

      task check_char(input logic [CHAR_WIDTH-1:0] character, input logic last_char);
         text_beat_type want;
         if (expected_text.size() == 0) begin
            report($sformatf("unexpected character %0d last=%0b", character, last_char));
         end else begin
            want = expected_text.pop_front();
            if (character !== want.character) begin
               report($sformatf("character %0d, expected %0d", character, want.character));
            end
            if (last_char !== want.last_char) begin
               report($sformatf("last_char %0b, expected %0b on character %0d",
                                last_char, want.last_char, want.character));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sitoa_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   sitoa_rsp_if                              rsp_bus ();

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   decimal_text_scoreboard tracker;

   int unsigned burst_left   = 0;
   int unsigned rx_cycles    = 0;
   int unsigned hold_left    = 0;
   bit          hold_active  = 1'b0;

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   // Receiver: rotate through stall patterns, with one long hold-off.
   always @(posedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
         hold_active   <= (hold_left != 1);
      end else if (rx_cycles == HOLD_START) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_active   <= 1'b1;
      end else begin
         case (rx_cycles[8:7])
            2'd0: rsp_bus.ready <= 1'b1;
            2'd1: rsp_bus.ready <= 1'($urandom_range(1, 0));
            2'd2: rsp_bus.ready <= ($urandom_range(3, 0) != 0);
            default: rsp_bus.ready <= ((rx_cycles % 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_value(req_bus.value);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_char(rsp_bus.character, rsp_bus.last_char);
         end
      end
   end

   // Offer one value, holding valid through a burst and dropping it in gaps.
   task offer_value(input logic [VALUE_WIDTH-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if (gap != 0 && !hold_active) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(16, 1);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // Let the monitor note the last accepted beat before checking the queue.
   task wait_for_text_drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.expected_text.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      longint      low_bound;
      longint      high_bound;
      int unsigned num_chars;
      logic [VALUE_WIDTH-1:0] value;
      case ($urandom_range(9, 0))
         0: value = $urandom;
         1: begin
            case ($urandom_range(2, 0))
               0: value = 32'h8000_0000 + $urandom_range(20, 0);
               1: value = 32'h7FFF_FFFF - $urandom_range(20, 0);
               default: value = $urandom_range(40, 0) - 20;
            endcase
         end
         default: begin
            num_chars  = $urandom_range(10, 1);
            low_bound  = (num_chars == 1) ? 0 : 10 ** (num_chars - 1);
            high_bound = 10 ** num_chars - 1;
            if (high_bound > 64'd2147483647) high_bound = 64'd2147483647;
            value = $urandom_range(int'(high_bound), int'(low_bound));
            if ($urandom_range(1, 0)) value = -value;
         end
      endcase
      return value;
   endfunction

   initial begin
      logic [VALUE_WIDTH-1:0] directed_values[$];
      tracker = new();
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      directed_values = '{
         32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
         -32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
         32'd1000000001, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001, 32'h8000_0000,
         32'd123456789, -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA,
         -32'sd5, 32'd42
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) offer_value(directed_values[i]);
      wait_for_text_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_text_drain();
         offer_value(random_value());
      end
      wait_for_text_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.expected_text.size() != 0) begin
         tracker.report($sformatf("%0d characters never arrived",
                                  tracker.expected_text.size()));
      end
      if (tracker.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[%0t] timeout", $time);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[signed_int_to_decimal_ascii.f]
hw/rtl/sitoa_pkg.sv
hw/rtl/sitoa_if.sv
hw/rtl/sitoa_datapath.sv
hw/rtl/sitoa_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
